// ===== rtl/acc_cpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acc_cpu_pkg
// Shared constants and controller/datapath interface types for the
// accumulator cpu execute block.
// ----------------------------------------------------------------------------
package acc_cpu_pkg;

   // default sizes
   localparam int DATA_DEPTH_DEFAULT = 256;
   localparam int PC_WIDTH_DEFAULT   = 16;

   // field widths
   localparam int OP_W     = 2;
   localparam int OPCODE_W = 4;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 9;
   localparam int RSP_PC_W = 16;

   localparam logic [SIZE_W-1:0] DATA_SIZE_RESET = 9'd256;

   // item kinds
   localparam logic [OP_W-1:0] OP_EXEC  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_RETI  = 2'd3;

   // instruction opcodes
   localparam logic [OPCODE_W-1:0] OPC_CARGI = 4'd0;
   localparam logic [OPCODE_W-1:0] OPC_CARGM = 4'd1;
   localparam logic [OPCODE_W-1:0] OPC_CARGX = 4'd2;
   localparam logic [OPCODE_W-1:0] OPC_ARMM  = 4'd3;
   localparam logic [OPCODE_W-1:0] OPC_ARMX  = 4'd4;
   localparam logic [OPCODE_W-1:0] OPC_SOMA  = 4'd5;
   localparam logic [OPCODE_W-1:0] OPC_NEG   = 4'd6;
   localparam logic [OPCODE_W-1:0] OPC_DESVZ = 4'd7;

   // cpu status codes
   localparam logic [STATUS_W-1:0] STATUS_NORMAL  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MEMVIOL = 2'd2;

   // accumulator update
   localparam logic [2:0] ACC_KEEP = 3'd0;
   localparam logic [2:0] ACC_ARG  = 3'd1;
   localparam logic [2:0] ACC_MEM  = 3'd2;
   localparam logic [2:0] ACC_ADD  = 3'd3;
   localparam logic [2:0] ACC_NEG  = 3'd4;

   // program counter update
   localparam logic [1:0] PC_KEEP = 2'd0;
   localparam logic [1:0] PC_INC  = 2'd1;
   localparam logic [1:0] PC_JUMP = 2'd2;

   // status update
   localparam logic [1:0] ST_KEEP    = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_MEMVIOL = 2'd2;
   localparam logic [1:0] ST_CLEAR   = 2'd3;

   // memory address source
   localparam logic ADDR_ARG = 1'b0;
   localparam logic ADDR_MEM = 1'b1;

   // memory write data source
   localparam logic WDATA_VALUE = 1'b0;
   localparam logic WDATA_ACC   = 1'b1;

   typedef struct packed {
      logic       load_req;
      logic       addr_sel;
      logic       mem_we;
      logic       wdata_sel;
      logic [2:0] acc_op;
      logic [1:0] pc_op;
      logic [1:0] st_op;
      logic       rd_load;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [OPCODE_W-1:0] opcode;
      logic                status_busy;
      logic                addr_ok;
      logic                acc_zero;
      logic                out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/acc_cpu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acc_cpu_ctrl
// Sequencer: walks each word through its execute, memory read and result
// steps and issues the datapath commands for each step.
// ----------------------------------------------------------------------------
module acc_cpu_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire acc_cpu_pkg::stat_type stat,
   output acc_cpu_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MEM1 = 3'd2;
   localparam logic [2:0] S_MEM2 = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       take_req;

   always_comb begin
      req_stall = 1'b1;
      if (state_ff == S_IDLE) begin
         req_stall = 1'b0;
      end else if (state_ff == S_DONE && stat.out_free) begin
         req_stall = 1'b0;
      end
   end

   assign take_req = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.addr_sel  = acc_cpu_pkg::ADDR_ARG;
      cmd.wdata_sel = acc_cpu_pkg::WDATA_VALUE;
      cmd.acc_op    = acc_cpu_pkg::ACC_KEEP;
      cmd.pc_op     = acc_cpu_pkg::PC_KEEP;
      cmd.st_op     = acc_cpu_pkg::ST_KEEP;
      case (state_ff)
         S_IDLE: begin
            if (take_req) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (stat.op)
               acc_cpu_pkg::OP_EXEC: begin
                  if (!stat.status_busy) begin
                     case (stat.opcode)
                        acc_cpu_pkg::OPC_CARGI: begin
                           cmd.acc_op = acc_cpu_pkg::ACC_ARG;
                           cmd.pc_op  = acc_cpu_pkg::PC_INC;
                        end
                        acc_cpu_pkg::OPC_CARGM, acc_cpu_pkg::OPC_CARGX,
                        acc_cpu_pkg::OPC_ARMX, acc_cpu_pkg::OPC_SOMA: begin
                           if (stat.addr_ok) begin
                              state_in = S_MEM1;
                           end else begin
                              cmd.st_op = acc_cpu_pkg::ST_MEMVIOL;
                           end
                        end
                        acc_cpu_pkg::OPC_ARMM: begin
                           if (stat.addr_ok) begin
                              cmd.mem_we    = 1'b1;
                              cmd.wdata_sel = acc_cpu_pkg::WDATA_ACC;
                              cmd.pc_op     = acc_cpu_pkg::PC_INC;
                           end else begin
                              cmd.st_op = acc_cpu_pkg::ST_MEMVIOL;
                           end
                        end
                        acc_cpu_pkg::OPC_NEG: begin
                           cmd.acc_op = acc_cpu_pkg::ACC_NEG;
                           cmd.pc_op  = acc_cpu_pkg::PC_INC;
                        end
                        acc_cpu_pkg::OPC_DESVZ: begin
                           cmd.pc_op = stat.acc_zero ? acc_cpu_pkg::PC_JUMP
                                                     : acc_cpu_pkg::PC_INC;
                        end
                        default: begin
                           cmd.st_op = acc_cpu_pkg::ST_ILLEGAL;
                        end
                     endcase
                  end
               end
               acc_cpu_pkg::OP_WRITE: begin
                  cmd.mem_we = stat.addr_ok;
               end
               acc_cpu_pkg::OP_READ: begin
                  if (stat.addr_ok) begin
                     state_in = S_MEM1;
                  end
               end
               default: begin
                  // return from interrupt
                  if (stat.status_busy) begin
                     cmd.st_op = acc_cpu_pkg::ST_CLEAR;
                     cmd.pc_op = acc_cpu_pkg::PC_INC;
                  end
               end
            endcase
         end
         S_MEM1: begin
            // read data now holds the word at the argument address
            cmd.addr_sel = acc_cpu_pkg::ADDR_MEM;
            state_in     = S_DONE;
            if (stat.op == acc_cpu_pkg::OP_READ) begin
               cmd.rd_load = 1'b1;
            end else begin
               case (stat.opcode)
                  acc_cpu_pkg::OPC_CARGM: begin
                     cmd.acc_op = acc_cpu_pkg::ACC_MEM;
                     cmd.pc_op  = acc_cpu_pkg::PC_INC;
                  end
                  acc_cpu_pkg::OPC_SOMA: begin
                     cmd.acc_op = acc_cpu_pkg::ACC_ADD;
                     cmd.pc_op  = acc_cpu_pkg::PC_INC;
                  end
                  acc_cpu_pkg::OPC_CARGX: begin
                     if (stat.addr_ok) begin
                        state_in = S_MEM2;
                     end else begin
                        cmd.st_op = acc_cpu_pkg::ST_MEMVIOL;
                     end
                  end
                  acc_cpu_pkg::OPC_ARMX: begin
                     if (stat.addr_ok) begin
                        cmd.mem_we    = 1'b1;
                        cmd.wdata_sel = acc_cpu_pkg::WDATA_ACC;
                        cmd.pc_op     = acc_cpu_pkg::PC_INC;
                     end else begin
                        cmd.st_op = acc_cpu_pkg::ST_MEMVIOL;
                     end
                  end
                  default: begin
                     cmd.acc_op = acc_cpu_pkg::ACC_KEEP;
                  end
               endcase
            end
         end
         S_MEM2: begin
            cmd.acc_op = acc_cpu_pkg::ACC_MEM;
            cmd.pc_op  = acc_cpu_pkg::PC_INC;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (take_req) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/acc_cpu_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acc_cpu_dpath
// Architectural registers, data memory, bounds check and the result
// register, driven by the sequencer commands.
// ----------------------------------------------------------------------------
module acc_cpu_dpath #(
   parameter int DATA_DEPTH = acc_cpu_pkg::DATA_DEPTH_DEFAULT,
   parameter int PC_WIDTH   = acc_cpu_pkg::PC_WIDTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire acc_cpu_pkg::cmd_type                    cmd,
   output acc_cpu_pkg::stat_type                        stat,
   input  wire logic        [acc_cpu_pkg::OP_W-1:0]     req_op,
   input  wire logic        [acc_cpu_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic signed [acc_cpu_pkg::WORD_W-1:0]   req_argument,
   input  wire logic signed [acc_cpu_pkg::WORD_W-1:0]   req_data_value,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic        [acc_cpu_pkg::SIZE_W-1:0]   csr_data_size,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic             [acc_cpu_pkg::RSP_PC_W-1:0] rsp_pc,
   output logic signed      [acc_cpu_pkg::WORD_W-1:0]   rsp_acc,
   output logic             [acc_cpu_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [acc_cpu_pkg::WORD_W-1:0]   rsp_read_data
);

   localparam int ADDR_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam logic [acc_cpu_pkg::WORD_W-1:0] DEPTH_WORD = 32'(DATA_DEPTH);

   // latched word
   logic [acc_cpu_pkg::OP_W-1:0]     op_ff;
   logic [acc_cpu_pkg::OPCODE_W-1:0] opcode_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   arg_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   value_ff;

   // architectural state
   logic [PC_WIDTH-1:0]              pc_ff;
   logic [PC_WIDTH-1:0]              pc_in;
   logic [acc_cpu_pkg::WORD_W-1:0]   acc_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   acc_in;
   logic [acc_cpu_pkg::STATUS_W-1:0] status_ff;
   logic [acc_cpu_pkg::STATUS_W-1:0] status_in;
   logic [acc_cpu_pkg::SIZE_W-1:0]   data_size_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   rd_ff;

   // data memory
   logic [acc_cpu_pkg::WORD_W-1:0]   mem [DATA_DEPTH];
   logic [acc_cpu_pkg::WORD_W-1:0]   mem_rdata_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   sel_addr;
   logic [ADDR_W-1:0]                mem_addr;
   logic [acc_cpu_pkg::WORD_W-1:0]   mem_wdata;
   logic [acc_cpu_pkg::WORD_W-1:0]   size_word;
   logic [acc_cpu_pkg::WORD_W-1:0]   bound;

   // result register
   logic                             rsp_valid_ff;
   logic [acc_cpu_pkg::RSP_PC_W-1:0] rsp_pc_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   rsp_acc_ff;
   logic [acc_cpu_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   rsp_rd_ff;
   logic [acc_cpu_pkg::WORD_W-1:0]   pc_wide;
   logic                             out_free;

   assign csr_ready = 1'b1;

   // one address serves the bounds check, the read port and the write port
   assign sel_addr  = (cmd.addr_sel == acc_cpu_pkg::ADDR_MEM) ? mem_rdata_ff : arg_ff;
   assign mem_addr  = sel_addr[ADDR_W-1:0];
   assign mem_wdata = (cmd.wdata_sel == acc_cpu_pkg::WDATA_ACC) ? acc_ff : value_ff;
   assign size_word = 32'(data_size_ff);
   assign bound     = (size_word < DEPTH_WORD) ? size_word : DEPTH_WORD;

   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.op          = op_ff;
      stat.opcode      = opcode_ff;
      stat.status_busy = (status_ff != acc_cpu_pkg::STATUS_NORMAL);
      stat.addr_ok     = (sel_addr < bound);
      stat.acc_zero    = (acc_ff == '0);
      stat.out_free    = out_free;
   end

   always_comb begin
      case (cmd.acc_op)
         acc_cpu_pkg::ACC_ARG: acc_in = arg_ff;
         acc_cpu_pkg::ACC_MEM: acc_in = mem_rdata_ff;
         acc_cpu_pkg::ACC_ADD: acc_in = acc_ff + mem_rdata_ff;
         acc_cpu_pkg::ACC_NEG: acc_in = '0 - acc_ff;
         default:              acc_in = acc_ff;
      endcase
   end

   always_comb begin
      case (cmd.pc_op)
         acc_cpu_pkg::PC_INC:  pc_in = pc_ff + PC_WIDTH'(1);
         acc_cpu_pkg::PC_JUMP: pc_in = arg_ff[PC_WIDTH-1:0];
         default:              pc_in = pc_ff;
      endcase
   end

   always_comb begin
      case (cmd.st_op)
         acc_cpu_pkg::ST_ILLEGAL: status_in = acc_cpu_pkg::STATUS_ILLEGAL;
         acc_cpu_pkg::ST_MEMVIOL: status_in = acc_cpu_pkg::STATUS_MEMVIOL;
         acc_cpu_pkg::ST_CLEAR:   status_in = acc_cpu_pkg::STATUS_NORMAL;
         default:                 status_in = status_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         acc_ff       <= '0;
         status_ff    <= acc_cpu_pkg::STATUS_NORMAL;
         data_size_ff <= acc_cpu_pkg::DATA_SIZE_RESET;
      end else begin
         pc_ff     <= pc_in;
         acc_ff    <= acc_in;
         status_ff <= status_in;
         if (csr_valid && csr_ready) begin
            data_size_ff <= csr_data_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_op;
         opcode_ff <= req_opcode;
         arg_ff    <= req_argument;
         value_ff  <= req_data_value;
      end
      if (cmd.load_req) begin
         rd_ff <= '0;
      end else if (cmd.rd_load) begin
         rd_ff <= mem_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   assign pc_wide = 32'(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pc_ff     <= pc_wide[acc_cpu_pkg::RSP_PC_W-1:0];
         rsp_acc_ff    <= acc_ff;
         rsp_status_ff <= status_ff;
         rsp_rd_ff     <= rd_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pc        = rsp_pc_ff;
   assign rsp_acc       = rsp_acc_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_rd_ff;

endmodule
`default_nettype wire

// ===== rtl/accumulator_cpu_execute_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_top
// Accumulator cpu core executing one decoded instruction, data access or
// interrupt return per request word.
// ----------------------------------------------------------------------------
// One request word gives one response word. A word that needs no data
// memory read (CARGI, ARMM, NEG, DESVZ, illegal opcodes, data writes,
// returns) passes through the execute and result steps only; a word that
// reads one word (CARGM, SOMA, ARMX, data reads) adds the first memory step
// and CARGX adds both memory steps; each dependent read adds a step because
// the single-port data memory has a registered read. A word that fails a
// bounds check, or an instruction skipped while the status is set, ends at
// the step where that is found. A new request is taken in the cycle the
// response register is loaded, so a waiting response only holds the core
// once a second one is ready. data_size may be written only while the core
// holds no word; the data memory is not cleared at reset.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_top #(
   parameter int DATA_DEPTH = acc_cpu_pkg::DATA_DEPTH_DEFAULT,
   parameter int PC_WIDTH   = acc_cpu_pkg::PC_WIDTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic        [acc_cpu_pkg::OP_W-1:0]     req_op,
   input  wire logic        [acc_cpu_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic signed [acc_cpu_pkg::WORD_W-1:0]   req_argument,
   input  wire logic signed [acc_cpu_pkg::WORD_W-1:0]   req_data_value,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic             [acc_cpu_pkg::RSP_PC_W-1:0] rsp_pc,
   output logic signed      [acc_cpu_pkg::WORD_W-1:0]   rsp_acc,
   output logic             [acc_cpu_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [acc_cpu_pkg::WORD_W-1:0]   rsp_read_data,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic        [acc_cpu_pkg::SIZE_W-1:0]   csr_data_size
);

   acc_cpu_pkg::cmd_type  cmd;
   acc_cpu_pkg::stat_type stat;

   acc_cpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   acc_cpu_dpath #(
      .DATA_DEPTH (DATA_DEPTH),
      .PC_WIDTH   (PC_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_op),
      .req_opcode     (req_opcode),
      .req_argument   (req_argument),
      .req_data_value (req_data_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data_size  (csr_data_size),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pc         (rsp_pc),
      .rsp_acc        (rsp_acc),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data)
   );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accumulator cpu execute block. A table of
// directed words runs first, then random instruction streams under a series
// of data_size settings. Both ends idle and stall at random. Each response
// is checked against a shadow copy of the cpu state or a typed row's value.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WORDS_PER_PHASE = 145;
   localparam int NUM_PHASES      = 7;
   localparam int MEM_WORDS       = 256;

   localparam logic [acc_cpu_pkg::OPCODE_W-1:0] OPC_ILLEGAL_LO = 4'd8;
   localparam logic [acc_cpu_pkg::OPCODE_W-1:0] OPC_ILLEGAL_HI = 4'd15;
   localparam logic [acc_cpu_pkg::OPCODE_W-1:0] OPC_NONE       = acc_cpu_pkg::OPC_CARGI;

   typedef struct packed {
      logic [15:0] pc;
      logic [31:0] acc;
      logic [1:0]  status;
      logic [31:0] rd;
   } cpu_rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  opcode;
      logic [31:0] arg;
      logic [31:0] value;
      logic        typed;
      cpu_rsp_type want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [3:0]         req_opcode;
   logic signed [31:0] req_argument;
   logic signed [31:0] req_data_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [15:0]        rsp_pc;
   logic signed [31:0] rsp_acc;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_read_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [8:0]         csr_data_size;

   // shadow cpu state
   logic [15:0] shadow_pc;
   logic [31:0] shadow_acc;
   logic [1:0]  shadow_status;
   logic [8:0]  shadow_size;
   logic [31:0] shadow_mem [0:MEM_WORDS-1];

   cpu_rsp_type  pending_rsp [$];
   stim_row_type directed_rows [$];
   int           err_count;
   int           sent_count;
   int           got_count;
   int           hold_left;
   int unsigned  cycles;

   accumulator_cpu_execute_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_opcode     (req_opcode),
      .req_argument   (req_argument),
      .req_data_value (req_data_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pc         (rsp_pc),
      .rsp_acc        (rsp_acc),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data_size  (csr_data_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic logic in_range(input logic [31:0] addr);
      int bound;
      bound = (shadow_size > MEM_WORDS) ? MEM_WORDS : int'(shadow_size);
      return addr < bound;
   endfunction

   task automatic predict_cpu_step(input logic [1:0] op, input logic [3:0] opc,
                                   input logic [31:0] arg, input logic [31:0] val,
                                   output cpu_rsp_type r);
      logic [31:0] ptr;
      logic [31:0] rd;
      rd = '0;
      case (op)
         acc_cpu_pkg::OP_EXEC: begin
            if (shadow_status == acc_cpu_pkg::STATUS_NORMAL) begin
               case (opc)
                  acc_cpu_pkg::OPC_CARGI: begin
                     shadow_acc = arg;
                     shadow_pc++;
                  end
                  acc_cpu_pkg::OPC_CARGM, acc_cpu_pkg::OPC_ARMM,
                  acc_cpu_pkg::OPC_SOMA: begin
                     if (!in_range(arg)) begin
                        shadow_status = acc_cpu_pkg::STATUS_MEMVIOL;
                     end else begin
                        if (opc == acc_cpu_pkg::OPC_CARGM) begin
                           shadow_acc = shadow_mem[arg[7:0]];
                        end else if (opc == acc_cpu_pkg::OPC_ARMM) begin
                           shadow_mem[arg[7:0]] = shadow_acc;
                        end else begin
                           shadow_acc = shadow_acc + shadow_mem[arg[7:0]];
                        end
                        shadow_pc++;
                     end
                  end
                  acc_cpu_pkg::OPC_CARGX, acc_cpu_pkg::OPC_ARMX: begin
                     if (!in_range(arg)) begin
                        shadow_status = acc_cpu_pkg::STATUS_MEMVIOL;
                     end else begin
                        ptr = shadow_mem[arg[7:0]];
                        if (!in_range(ptr)) begin
                           shadow_status = acc_cpu_pkg::STATUS_MEMVIOL;
                        end else begin
                           if (opc == acc_cpu_pkg::OPC_CARGX) shadow_acc = shadow_mem[ptr[7:0]];
                           else shadow_mem[ptr[7:0]] = shadow_acc;
                           shadow_pc++;
                        end
                     end
                  end
                  acc_cpu_pkg::OPC_NEG: begin
                     shadow_acc = -shadow_acc;
                     shadow_pc++;
                  end
                  acc_cpu_pkg::OPC_DESVZ: begin
                     if (shadow_acc == 0) shadow_pc = arg[15:0];
                     else shadow_pc++;
                  end
                  default: shadow_status = acc_cpu_pkg::STATUS_ILLEGAL;
               endcase
            end
         end
         acc_cpu_pkg::OP_WRITE: begin
            if (in_range(arg)) shadow_mem[arg[7:0]] = val;
         end
         acc_cpu_pkg::OP_READ: begin
            if (in_range(arg)) rd = shadow_mem[arg[7:0]];
         end
         default: begin
            if (shadow_status != acc_cpu_pkg::STATUS_NORMAL) begin
               shadow_status = acc_cpu_pkg::STATUS_NORMAL;
               shadow_pc++;
            end
         end
      endcase
      r = '{shadow_pc, shadow_acc, shadow_status, rd};
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      $display("ERROR rsp %0d %s: got %h, want %h", got_count, what, got, want);
   endtask

   task automatic check_rsp();
      cpu_rsp_type want;
      got_count++;
      // long hold-off so the core backs up and stalls its request side
      if (got_count == 300) hold_left = 200;
      if (pending_rsp.size() == 0) begin
         report_mismatch("unexpected word", rsp_acc, '0);
         return;
      end
      want = pending_rsp.pop_front();
      if (rsp_pc !== want.pc) report_mismatch("pc", 32'(rsp_pc), 32'(want.pc));
      if (rsp_acc !== want.acc) report_mismatch("acc", rsp_acc, want.acc);
      if (rsp_status !== want.status) begin
         report_mismatch("status", 32'(rsp_status), 32'(want.status));
      end
      if (rsp_read_data !== want.rd) report_mismatch("read_data", rsp_read_data, want.rd);
   endtask

   // response side
   initial begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      got_count = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_rsp();
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (got_count >= 580 && got_count < 760) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 19);
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [3:0] opc,
                            input logic [31:0] arg, input logic [31:0] val,
                            input logic typed, input cpu_rsp_type want);
      cpu_rsp_type predicted;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_opcode     <= opc;
      req_argument   <= arg;
      req_data_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cpu_step(op, opc, arg, val, predicted);
      pending_rsp.push_back(typed ? want : predicted);
      sent_count++;
      if (!(sent_count >= 600 && sent_count < 760) && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_data_size(input logic [8:0] size);
      csr_valid     <= 1'b1;
      csr_data_size <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      shadow_size = size;
   endtask

   function automatic logic [31:0] pick_addr();
      int bound;
      bound = (shadow_size > MEM_WORDS) ? MEM_WORDS : int'(shadow_size);
      if ($urandom_range(99) < 85) return 32'($urandom_range(0, bound + 2));
      return $urandom;
   endfunction

   // data words lean toward small values so indirect modes often stay in range
   function automatic logic [31:0] pick_word();
      if ($urandom_range(99) < 50) return 32'($urandom_range(0, 300));
      return $urandom;
   endfunction

   task automatic random_item(output logic [1:0] op, output logic [3:0] opc,
                              output logic [31:0] arg, output logic [31:0] val);
      int r;
      r   = $urandom_range(99);
      opc = OPC_NONE;
      arg = pick_addr();
      val = pick_word();
      if (shadow_status != acc_cpu_pkg::STATUS_NORMAL && $urandom_range(99) < 70) begin
         op = acc_cpu_pkg::OP_RETI;
      end else if (r < 72) op = acc_cpu_pkg::OP_EXEC;
      else if (r < 84) op = acc_cpu_pkg::OP_WRITE;
      else if (r < 94) op = acc_cpu_pkg::OP_READ;
      else op = acc_cpu_pkg::OP_RETI;
      if (op == acc_cpu_pkg::OP_EXEC) begin
         if ($urandom_range(99) < 5) begin
            opc = 4'($urandom_range(OPC_ILLEGAL_LO, OPC_ILLEGAL_HI));
         end else begin
            opc = 4'($urandom_range(acc_cpu_pkg::OPC_CARGI, acc_cpu_pkg::OPC_DESVZ));
         end
         if (opc == acc_cpu_pkg::OPC_CARGI) arg = ($urandom_range(99) < 15) ? '0 : $urandom;
         else if (opc == acc_cpu_pkg::OPC_DESVZ) arg = $urandom;
      end
      // noise words: opcode bits toggle even when unused
      if (op != acc_cpu_pkg::OP_EXEC) opc = 4'($urandom_range(0, 15));
   endtask

   task automatic add_row(input logic [1:0] op, input logic [3:0] opc,
                          input logic [31:0] arg, input logic [31:0] val);
      directed_rows.push_back('{op, opc, arg, val, 1'b0, cpu_rsp_type'('0)});
   endtask

   task automatic add_typed(input logic [1:0] op, input logic [3:0] opc,
                            input logic [31:0] arg, input logic [31:0] val,
                            input logic [15:0] pc, input logic [31:0] acc,
                            input logic [1:0] st, input logic [31:0] rd);
      directed_rows.push_back('{op, opc, arg, val, 1'b1, cpu_rsp_type'{pc, acc, st, rd}});
   endtask

   initial begin
      logic [8:0]  phase_sizes [NUM_PHASES];
      logic [1:0]  op;
      logic [3:0]  opc;
      logic [31:0] arg;
      logic [31:0] val;
      int          counted;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= acc_cpu_pkg::OP_EXEC;
      req_opcode     <= OPC_NONE;
      req_argument   <= '0;
      req_data_value <= '0;
      csr_valid      <= 1'b0;
      csr_data_size  <= acc_cpu_pkg::DATA_SIZE_RESET;
      err_count      = 0;
      sent_count     = 0;
      shadow_pc      = '0;
      shadow_acc     = '0;
      shadow_status  = acc_cpu_pkg::STATUS_NORMAL;
      shadow_size    = acc_cpu_pkg::DATA_SIZE_RESET;

      add_typed(acc_cpu_pkg::OP_RETI, OPC_NONE, '0, '0, 16'd0, 32'd0,
                acc_cpu_pkg::STATUS_NORMAL, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGI, 32'h7fff_ffff, '0,
                16'd1, 32'h7fff_ffff, acc_cpu_pkg::STATUS_NORMAL, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_NEG, '0, '0,
                16'd2, 32'h8000_0001, acc_cpu_pkg::STATUS_NORMAL, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGI, 32'h8000_0000, '0,
                16'd3, 32'h8000_0000, acc_cpu_pkg::STATUS_NORMAL, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_NEG, '0, '0,
                16'd4, 32'h8000_0000, acc_cpu_pkg::STATUS_NORMAL, '0);
      add_row(acc_cpu_pkg::OP_WRITE, OPC_NONE, 32'd0, 32'd5);
      add_row(acc_cpu_pkg::OP_WRITE, OPC_NONE, 32'd5, 32'hffff_ffff);
      add_row(acc_cpu_pkg::OP_WRITE, OPC_NONE, 32'd255, 32'h7fff_ffff);
      add_row(acc_cpu_pkg::OP_WRITE, OPC_NONE, 32'd256, 32'h1234_5678);
      add_row(acc_cpu_pkg::OP_READ, OPC_NONE, 32'd255, '0);
      add_typed(acc_cpu_pkg::OP_READ, OPC_NONE, 32'hffff_ffff, '0,
                16'd4, 32'h8000_0000, acc_cpu_pkg::STATUS_NORMAL, '0);
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGM, 32'd0, '0);
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGX, 32'd0, '0);
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_SOMA, 32'd255, '0);
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_ARMM, 32'd1, '0);
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_ARMX, 32'd0, '0);
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGI, 32'd0, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_DESVZ, 32'hffff_ffff, '0,
                16'hffff, 32'd0, acc_cpu_pkg::STATUS_NORMAL, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGI, 32'd3, '0,
                16'd0, 32'd3, acc_cpu_pkg::STATUS_NORMAL, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGM, 32'd256, '0,
                16'd0, 32'd3, acc_cpu_pkg::STATUS_MEMVIOL, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGI, 32'd9, '0,
                16'd0, 32'd3, acc_cpu_pkg::STATUS_MEMVIOL, '0);
      add_row(acc_cpu_pkg::OP_WRITE, OPC_NONE, 32'd2, 32'd300);
      add_row(acc_cpu_pkg::OP_READ, OPC_NONE, 32'd1, '0);
      add_typed(acc_cpu_pkg::OP_RETI, OPC_NONE, '0, '0, 16'd1, 32'd3,
                acc_cpu_pkg::STATUS_NORMAL, '0);
      // indirect pointer out of range, then first address out of range
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_CARGX, 32'd2, '0);
      add_row(acc_cpu_pkg::OP_RETI, OPC_NONE, '0, '0);
      add_row(acc_cpu_pkg::OP_EXEC, acc_cpu_pkg::OPC_ARMX, 32'd300, '0);
      add_row(acc_cpu_pkg::OP_RETI, OPC_NONE, '0, '0);
      add_typed(acc_cpu_pkg::OP_EXEC, OPC_ILLEGAL_HI, '0, '0, 16'd3, 32'd3,
                acc_cpu_pkg::STATUS_ILLEGAL, '0);

      phase_sizes = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd7, 9'd257,
                      9'($urandom_range(2, 255))};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].opcode, directed_rows[i].arg,
                   directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         quiesce();
         write_data_size(phase_sizes[p]);
         // fill every word once so no later read hits an unwritten one
         if (p == 0) begin
            for (int a = 0; a < MEM_WORDS; a++) begin
               send_item(acc_cpu_pkg::OP_WRITE, 4'($urandom_range(0, 15)), 32'(a),
                         pick_word(), 1'b0, '0);
            end
         end
         counted = 0;
         while (counted < WORDS_PER_PHASE) begin
            random_item(op, opc, arg, val);
            if (!(op == acc_cpu_pkg::OP_EXEC &&
                  shadow_status != acc_cpu_pkg::STATUS_NORMAL)) counted++;
            send_item(op, opc, arg, val, 1'b0, '0);
         end
      end

      quiesce();
      if (pending_rsp.size() != 0) begin
         report_mismatch("words never returned", 32'(pending_rsp.size()), '0);
      end
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/acc_cpu_pkg.sv
rtl/acc_cpu_ctrl.sv
rtl/acc_cpu_dpath.sv
rtl/accumulator_cpu_execute_top.sv
bench/tb_top.sv
